>>> hdl/rbd_pkg.sv
// Shared types and codes for the ring buffer deque.
package rbd_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_status;

    localparam t_kind KIND_PUSH_BACK  = 3'd0;
    localparam t_kind KIND_PUSH_FRONT = 3'd1;
    localparam t_kind KIND_POP_FRONT  = 3'd2;
    localparam t_kind KIND_POP_BACK   = 3'd3;
    localparam t_kind KIND_PEEK_FRONT = 3'd4;
    localparam t_kind KIND_PEEK_BACK  = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Memory access and outcome of one request
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        t_status status;
    } t_op_ctl;

endpackage

>>> hdl/rbd_chan_if.sv
// Request and response channels of the ring buffer deque.
interface rbd_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] push_word;

    modport source (output valid, output kind, output push_word, input ready);
    modport sink (input valid, input kind, input push_word, output ready);
endinterface

interface rbd_rsp_if #(
    parameter int CNT_W = $clog2(rbd_pkg::DEFAULT_CAPACITY + 1)
);
    logic             valid;
    logic             ready;
    logic [63:0]      read_word;
    logic [1:0]       status;
    logic [CNT_W-1:0] fill_count;
    logic             is_empty;

    modport source (output valid, output read_word, output status, output fill_count,
                    output is_empty, input ready);
    modport sink (input valid, input read_word, input status, input fill_count,
                  input is_empty, output ready);
endinterface

>>> hdl/rbd_ptr.sv
// Head and count update and slot address for one deque request.
module rbd_ptr #(
    parameter int CAPACITY = rbd_pkg::DEFAULT_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  rbd_pkg::t_kind   i_kind,
    input  logic [IDX_W-1:0] i_head,
    input  logic [CNT_W-1:0] i_count,
    output rbd_pkg::t_op_ctl o_ctl,
    output logic [IDX_W-1:0] o_addr,
    output logic [IDX_W-1:0] o_head,
    output logic [CNT_W-1:0] o_count
);
    import rbd_pkg::*;

    localparam int SUM_W = $clog2(2 * CAPACITY);
    localparam logic [SUM_W-1:0] CAP_S   = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAPACITY - 1);

    logic             full;
    logic             empty;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] head_inc;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] back_sum;
    logic [IDX_W-1:0] tail_slot;
    logic [IDX_W-1:0] back_slot;

    assign full     = (i_count >= CAP_C);
    assign empty    = (i_count == '0);
    assign head_dec = (i_head == '0) ? LAST_IX : i_head - IDX_W'(1);
    assign head_inc = (i_head == LAST_IX) ? '0 : i_head + IDX_W'(1);

    // Sums stay below twice the capacity: one conditional subtract wraps them
    assign tail_sum  = SUM_W'(i_head) + SUM_W'(i_count);
    assign back_sum  = tail_sum - SUM_W'(1);
    assign tail_slot = IDX_W'((tail_sum >= CAP_S) ? tail_sum - CAP_S : tail_sum);
    assign back_slot = IDX_W'((back_sum >= CAP_S) ? back_sum - CAP_S : back_sum);

    always_comb begin
        o_ctl   = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_OK};
        o_addr  = i_head;
        o_head  = i_head;
        o_count = i_count;
        case (i_kind)
            KIND_PUSH_BACK: begin
                if (full) begin
                    o_ctl.status = ST_FULL;
                end else begin
                    o_ctl.wr_en = 1'b1;
                    o_addr      = tail_slot;
                    o_count     = i_count + CNT_W'(1);
                end
            end
            KIND_PUSH_FRONT: begin
                if (full) begin
                    o_ctl.status = ST_FULL;
                end else begin
                    o_ctl.wr_en = 1'b1;
                    o_addr      = head_dec;
                    o_head      = head_dec;
                    o_count     = i_count + CNT_W'(1);
                end
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT: begin
                if (empty) begin
                    o_ctl.status = ST_EMPTY;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    o_addr      = i_head;
                    if (i_kind == KIND_POP_FRONT) begin
                        o_head  = head_inc;
                        o_count = i_count - CNT_W'(1);
                    end
                end
            end
            KIND_POP_BACK, KIND_PEEK_BACK: begin
                if (empty) begin
                    o_ctl.status = ST_EMPTY;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    o_addr      = back_slot;
                    if (i_kind == KIND_POP_BACK) begin
                        o_count = i_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                // unused kind: no operation, report the current count
                o_ctl.status = ST_OK;
            end
        endcase
    end

endmodule

>>> hdl/ring_buffer_deque.sv
// Top level of the ring buffer deque: pointer registers, word store and response stages.
// Double-ended queue of CAPACITY 64-bit words in a single-port ring memory. Each request
// (push back/front, pop front/back, peek front/back) yields one response carrying the word
// read, a status, the count after the request and an empty flag. Requests are taken one per
// cycle while the response path is not stalled; a response passes through stage one, where
// the memory read is registered, and then the output register. Head and count update at
// the accept edge, so a request always sees the writes of every earlier one and no
// forwarding is needed. The memory has no reset: only written slots are ever read.
module ring_buffer_deque #(
    parameter int CAPACITY = rbd_pkg::DEFAULT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbd_req_if.sink   i_req,
    rbd_rsp_if.source o_rsp
);
    import rbd_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [63:0]      r_mem [CAPACITY];
    logic [63:0]      r_rd_data;
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;

    logic             r_s1_valid;
    logic             r_s1_rd;
    t_status          r_s1_status;
    logic [CNT_W-1:0] r_s1_count;

    logic             r_out_valid;
    logic [63:0]      r_out_word;
    t_status          r_out_status;
    logic [CNT_W-1:0] r_out_count;

    t_op_ctl          ctl;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] n_head;
    logic [CNT_W-1:0] n_count;
    logic             out_free;
    logic             s1_adv;
    logic             accept;

    rbd_ptr #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ptr (
        .i_kind  (i_req.kind),
        .i_head  (r_head),
        .i_count (r_count),
        .o_ctl   (ctl),
        .o_addr  (addr),
        .o_head  (n_head),
        .o_count (n_count)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || out_free;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (accept && ctl.wr_en) begin
            r_mem[addr] <= i_req.push_word;
        end
    end

    // Read data holds while stage one stalls: no request is taken then
    always_ff @(posedge i_clk) begin
        if (accept && ctl.rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd     <= ctl.rd_en;
            r_s1_status <= ctl.status;
            r_s1_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_word   <= r_s1_rd ? r_rd_data : 64'd0;
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_word  = r_out_word;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.fill_count = r_out_count;
    assign o_rsp.is_empty   = (r_out_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= IDX_W'(CAPACITY - 1))
        else $error("head index outside the ring");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ctl.wr_en |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted push did not grow the count");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == ST_EMPTY || r_out_status == ST_FULL)
            |-> r_out_word == 64'd0)
        else $error("refused request returned a nonzero word");

endmodule

>>> tb/ring_buffer_deque_test.sv
// Self-checking testbench for the ring buffer deque: random requests with a tracking model.
`timescale 1ns / 1ps

module ring_buffer_deque_test;
    import rbd_pkg::*;

    localparam int DEPTH = DEFAULT_CAPACITY;
    localparam int RANDOM_REQUESTS = 900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_POINT = 450;

    // Kinds the block treats as no-ops
    localparam t_kind KIND_UNUSED_6 = 3'd6;
    localparam t_kind KIND_UNUSED_7 = 3'd7;

    typedef struct {
        t_kind       kind;
        logic [63:0] word;
        int unsigned gap_after;
        bit          drain_first;
    } t_deque_req;

    typedef struct packed {
        logic [63:0] read_word;
        t_status     status;
        logic [4:0]  fill_count;
        logic        is_empty;
    } t_deque_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rbd_req_if req ();
    rbd_rsp_if rsp ();

    ring_buffer_deque #(
        .CAPACITY(DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    always #5 i_clk = ~i_clk;

    // Tracking copy of the deque
    logic [63:0] deque_slots [DEPTH];
    int unsigned deque_head;
    int unsigned deque_count;

    t_deque_req  req_pending_q[$];
    t_deque_rsp  rsp_expected_q[$];

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned req_accepted;
    bit          req_taken;
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned stall_left;
    bit [1:0]    long_hold_done;

    function automatic t_deque_rsp deque_apply(input t_kind op, input logic [63:0] word);
        t_deque_rsp r;
        r.read_word = '0;
        r.status = ST_OK;
        case (op)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (deque_count == DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == KIND_PUSH_BACK) begin
                    deque_slots[(deque_head + deque_count) % DEPTH] = word;
                    deque_count++;
                end else begin
                    // step the head back one slot, wrapping below slot zero
                    deque_head = (deque_head + DEPTH - 1) % DEPTH;
                    deque_slots[deque_head] = word;
                    deque_count++;
                end
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT: begin
                if (deque_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_word = deque_slots[deque_head];
                    if (op == KIND_POP_FRONT) begin
                        deque_head = (deque_head + 1) % DEPTH;
                        deque_count--;
                    end
                end
            end
            KIND_POP_BACK, KIND_PEEK_BACK: begin
                if (deque_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_word = deque_slots[(deque_head + deque_count - 1) % DEPTH];
                    if (op == KIND_POP_BACK) begin
                        deque_count--;
                    end
                end
            end
            default: ;
        endcase
        r.fill_count = deque_count[4:0];
        r.is_empty = (deque_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_request(input t_kind op, input logic [63:0] word,
                                 input int unsigned gap, input bit drain);
        t_deque_req r;
        r.kind = op;
        r.word = word;
        r.gap_after = gap;
        r.drain_first = drain;
        req_pending_q.push_back(r);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin : watch_channels
        t_deque_rsp got;
        t_deque_rsp want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got = '{rsp.read_word, rsp.status, rsp.fill_count, rsp.is_empty};
            if (rsp_expected_q.size() == 0) begin
                report_mismatch("response with no request outstanding", got.read_word, '0);
            end else begin
                want = rsp_expected_q.pop_front();
                if (got.read_word !== want.read_word)
                    report_mismatch("read_word", got.read_word, want.read_word);
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.fill_count !== want.fill_count)
                    report_mismatch("fill_count", 64'(got.fill_count), 64'(want.fill_count));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
            end
        end
        if (i_rst_n && req.valid && req.ready) begin
            rsp_expected_q.push_back(deque_apply(req.kind, req.push_word));
            req_taken = 1'b1;
            req_accepted++;
        end
    end

    // Request driver: hold until accepted, then idle or advance
    always @(negedge i_clk) begin : drive_requests
        t_deque_req nxt;
        if (!i_rst_n) begin
            req.valid <= 1'b0;
        end else if (req.valid && !req_taken) begin
            // hold the request
        end else if (gap_left > 0) begin
            req.valid <= 1'b0;
            gap_left--;
        end else if (req_pending_q.size() > 0
                     && !(req_pending_q[0].drain_first && rsp_expected_q.size() > 0)) begin
            nxt = req_pending_q.pop_front();
            req.valid <= 1'b1;
            req.kind <= nxt.kind;
            req.push_word <= nxt.word;
            gap_left = nxt.gap_after;
        end else begin
            req.valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // Response ready: random stalls, quiet stretches and two long hold-offs
    always @(negedge i_clk) begin : drive_ready
        int unsigned roll;
        if (!long_hold_done[0] && req_accepted >= 150) begin
            hold_left = 80;
            long_hold_done[0] = 1'b1;
        end
        if (!long_hold_done[1] && req_accepted >= 600) begin
            hold_left = 120;
            long_hold_done[1] = 1'b1;
        end
        if (hold_left > 0) begin
            rsp.ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
        end else if ((cycle_count / 256) % 3 == 0) begin
            rsp.ready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                rsp.ready <= 1'b1;
            end else begin
                rsp.ready <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ring_buffer_deque_test: done, errors");
            $finish;
        end
    end

    initial begin : run
        int unsigned n;
        int unsigned len;
        int unsigned push_pct;
        int unsigned roll;
        int unsigned mode;
        bit          quiet;
        t_kind       op;

        i_rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_PUSH_BACK;
        req.push_word = '0;
        rsp.ready = 1'b0;
        deque_head = 0;
        deque_count = 0;

        // Empty-store errors, no-op kinds, wrap of the head on push front
        queue_request(KIND_POP_FRONT, 64'h0123_4567_89ab_cdef, 0, 1'b0);
        queue_request(KIND_POP_BACK, '1, 0, 1'b0);
        queue_request(KIND_PEEK_FRONT, '0, 1, 1'b0);
        queue_request(KIND_PEEK_BACK, '0, 0, 1'b0);
        queue_request(KIND_UNUSED_6, '1, 0, 1'b0);
        queue_request(KIND_UNUSED_7, '0, 0, 1'b0);
        queue_request(KIND_PUSH_BACK, '0, 0, 1'b0);
        queue_request(KIND_PUSH_FRONT, '1, 0, 1'b0);
        queue_request(KIND_PUSH_BACK, 64'h8000_0000_0000_0001, 2, 1'b0);
        queue_request(KIND_PEEK_FRONT, '0, 0, 1'b0);
        queue_request(KIND_PEEK_BACK, '0, 0, 1'b0);
        queue_request(KIND_UNUSED_6, '0, 0, 1'b0);
        queue_request(KIND_POP_BACK, '0, 0, 1'b0);
        queue_request(KIND_POP_FRONT, '0, 0, 1'b0);
        queue_request(KIND_PEEK_BACK, '0, 0, 1'b0);
        queue_request(KIND_POP_FRONT, '0, 0, 1'b0);
        queue_request(KIND_POP_BACK, '0, 0, 1'b0);

        // Phases biased toward filling, draining, mixing or peeking
        n = 0;
        while (n < RANDOM_REQUESTS) begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(15, 50);
            quiet = ($urandom_range(0, 3) == 0);
            case (mode)
                0: push_pct = 80;
                1: push_pct = 15;
                2: push_pct = 45;
                default: push_pct = 35;
            endcase
            for (int i = 0; i < len; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    op = $urandom_range(0, 1) ? KIND_UNUSED_7 : KIND_UNUSED_6;
                end else if (roll < push_pct + 2) begin
                    op = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
                end else if ($urandom_range(0, 99) < ((mode == 3) ? 70 : 30)) begin
                    op = $urandom_range(0, 1) ? KIND_PEEK_FRONT : KIND_PEEK_BACK;
                end else begin
                    op = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
                end
                queue_request(op, {$urandom, $urandom}, quiet ? 0 : pick_gap(),
                              n == DRAIN_POINT);
                n++;
            end
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_pending_q.size() > 0 || req.valid) @(posedge i_clk);
        while (rsp_expected_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && rsp_expected_q.size() == 0) begin
            $display("ring_buffer_deque_test: done, clean");
        end else begin
            $display("ring_buffer_deque_test: done, errors");
        end
        $finish;
    end

endmodule
